// File: design/ocg_pkg.sv
// ----------------------------------------------------------------------------
// ocg_pkg
// Shared constants and types for the child octet gather block.
// ----------------------------------------------------------------------------
package ocg_pkg;
    localparam int TABLE_DEPTH  = 4096;
    localparam int BISECT_STEPS = 12;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int SW = $clog2(BISECT_STEPS + 1);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic start;     // latch query, clear slots
        logic bis_rd;    // issue bisect read
        logic bis_upd;   // update bracket from read data
        logic scan_init; // set scan pointer to a
        logic scan_rd;   // issue scan read
        logic scan_chk;  // test read data
        logic emit_init;
        logic emit_next;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic scan_done; // pointer past b
    } t_sts;
endpackage

// File: design/ocg_ctrl.sv
// ----------------------------------------------------------------------------
// ocg_ctrl
// Query sequencer: bisection, bracket scan and slot emission.
// ----------------------------------------------------------------------------
module ocg_ctrl
    import ocg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  t_sts       i_sts,
    input  logic       i_out_taken,
    input  logic       i_emit_last,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_out_valid
);
    localparam logic [2:0] S_IDLE = 3'd0, S_BRD = 3'd1, S_BUP = 3'd2,
                           S_SRD = 3'd3, S_SCHK = 3'd4, S_EMIT = 3'd5;
    logic [2:0]    r_st, n_st;
    logic [SW-1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_k  <= '0;
        end else begin
            r_st <= n_st;
            r_k  <= n_k;
        end
    end

    always_comb begin
        n_st  = r_st;
        n_k   = r_k;
        o_cmd = '0;
        case (r_st)
            S_IDLE: begin
                if (i_go) begin
                    o_cmd.start = 1'b1;
                    n_k = '0;
                    if (i_sts.empty) begin
                        o_cmd.emit_init = 1'b1;
                        n_st = S_EMIT;
                    end else begin
                        n_st = S_BRD;
                    end
                end
            end
            S_BRD: begin
                o_cmd.bis_rd = 1'b1;
                n_st = S_BUP;
            end
            S_BUP: begin
                o_cmd.bis_upd = 1'b1;
                n_k = r_k + 1'b1;
                if (r_k == SW'(BISECT_STEPS - 1)) begin
                    o_cmd.scan_init = 1'b1;
                    n_st = S_SRD;
                end else begin
                    n_st = S_BRD;
                end
            end
            S_SRD: begin
                if (i_sts.scan_done) begin
                    o_cmd.emit_init = 1'b1;
                    n_st = S_EMIT;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_st = S_SCHK;
                end
            end
            S_SCHK: begin
                o_cmd.scan_chk = 1'b1;
                n_st = S_SRD;
            end
            S_EMIT: begin
                if (i_out_taken) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_emit_last) n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_busy      = (r_st != S_IDLE);
    assign o_out_valid = (r_st == S_EMIT);
endmodule

// File: design/ocg_dp.sv
// ----------------------------------------------------------------------------
// ocg_dp
// Child table memory, bracket registers, window tests and octet slots.
// ----------------------------------------------------------------------------
module ocg_dp
    import ocg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_clear,
    input  logic [24:0] i_cell_size,
    input  logic [24:0] i_coord_x,
    input  logic [24:0] i_coord_y,
    input  logic [24:0] i_coord_z,
    input  logic [31:0] i_payload,
    input  logic [23:0] i_parent_index,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_emit_last,
    output logic [23:0] o_parent_echo,
    output logic [2:0]  o_octant,
    output logic [24:0] o_out_x,
    output logic [24:0] o_out_y,
    output logic [24:0] o_out_z,
    output logic [31:0] o_out_value,
    output logic        o_slot_found,
    output logic [7:0]  o_found_count,
    output logic        o_count_wrong
);
    logic [113:0] r_mem [TABLE_DEPTH];
    logic [113:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [24:0] r_px, r_py, r_pz, r_w;
    logic [25:0] r_zhi;
    logic [26:0] r_zlo;
    logic [23:0] r_pidx;
    logic [AW-1:0] r_a, r_b, r_c;
    logic [CW-1:0] r_j;
    logic [8:0] r_found;
    logic [7:0] r_fill;
    logic [106:0] r_oct [8];
    logic [2:0] r_k;
    logic [26:0] w_mul;
    logic [54:0] w_prod;
    logic [24:0] w_w;
    logic [24:0] cx, cy, cz, dx, dy, dz;
    logic        hit;
    logic [2:0]  slot;

    // 3*D/10 by reciprocal ceil(2^31/10), exact over 27-bit operands
    assign w_mul  = {i_cell_size, 1'b0} + {2'b0, i_cell_size};
    assign w_prod = 55'(w_mul) * 55'd214748365;
    assign w_w    = {1'b0, w_prod[54:31]};

    always_ff @(posedge i_clk) begin
        if (i_load && r_cnt != CW'(TABLE_DEPTH))
            r_mem[r_cnt[AW-1:0]] <= {i_coord_x, i_coord_y, i_coord_z, i_payload, 7'd0};
        if (i_cmd.bis_rd || i_cmd.scan_rd)
            r_rd <= r_mem[i_cmd.bis_rd ? r_c : r_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else if (i_clear) r_cnt <= '0;
        else if (i_load && r_cnt != CW'(TABLE_DEPTH)) r_cnt <= r_cnt + 1'b1;
    end

    assign cx = r_rd[113:89];
    assign cy = r_rd[88:64];
    assign cz = r_rd[63:39];
    assign dx = (r_px > cx) ? r_px - cx : cx - r_px;
    assign dy = (r_py > cy) ? r_py - cy : cy - r_py;
    assign dz = (r_pz > cz) ? r_pz - cz : cz - r_pz;
    assign hit = (dx < r_w) && (dy < r_w) && (dz < r_w);
    assign slot = {~(cz < r_pz), ~(cy < r_py), ~(cx < r_px)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_k    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_px <= i_coord_x; r_py <= i_coord_y; r_pz <= i_coord_z;
                r_w  <= w_w;
                r_zhi <= {1'b0, i_coord_z} + {1'b0, w_w};
                r_zlo <= {2'b0, i_coord_z} - {2'b0, w_w};
                r_pidx <= i_parent_index;
                r_a <= '0;
                r_b <= AW'(r_cnt - 1'b1);
                r_c <= AW'((CW'(0) + r_cnt - 1'b1) >> 1);
                r_found <= '0;
                r_fill <= '0;
            end
            if (i_cmd.bis_upd) begin
                logic [AW-1:0] na, nb;
                logic [AW:0]   s2;
                na = r_a; nb = r_b;
                if ({1'b0, cz} > r_zhi) nb = r_c;
                else if (!r_zlo[26] && {2'b0, cz} < r_zlo) na = r_c;
                r_a <= na; r_b <= nb;
                s2 = {1'b0, na} + {1'b0, nb};
                r_c <= s2[AW:1];
                // scan starts from the bracket left by the final step
                if (i_cmd.scan_init) r_j <= {1'b0, na};
            end
            if (i_cmd.scan_rd)   r_j <= r_j + 1'b1;
            if (i_cmd.scan_chk && hit) begin
                r_oct[slot] <= {cx, cy, cz, r_rd[38:7]};
                r_fill[slot] <= 1'b1;
                if (r_found != 9'h1FF) r_found <= r_found + 1'b1;
            end
            if (i_cmd.emit_init) r_k <= '0;
            if (i_cmd.emit_next) r_k <= r_k + 1'b1;
        end
    end

    assign o_sts.empty     = (r_cnt == '0);
    assign o_sts.scan_done = (r_j > {1'b0, r_b});
    assign o_emit_last     = (r_k == 3'd7);
    assign o_parent_echo   = r_pidx;
    assign o_octant        = r_k;
    assign o_slot_found    = r_fill[r_k];
    assign o_out_x     = r_fill[r_k] ? r_oct[r_k][106:82] : '0;
    assign o_out_y     = r_fill[r_k] ? r_oct[r_k][81:57]  : '0;
    assign o_out_z     = r_fill[r_k] ? r_oct[r_k][56:32]  : '0;
    assign o_out_value = r_fill[r_k] ? r_oct[r_k][31:0]   : '0;
    assign o_found_count = (r_found > 9'd255) ? 8'd255 : r_found[7:0];
    assign o_count_wrong = (r_found != 9'd8);
endmodule

// File: design/octree_child_octet_gather.sv
// A query runs 12 bisection steps, each a read state then an update state,
// then scans the bracket, reading and checking one entry at a time until the
// pointer passes b, then 8 result transfers; an empty table skips to those.
// Loads and clears are taken only when idle; one item is processed at a time.
// Reset (synchronous, active low) empties the table and sets cell_size 65536.
// ----------------------------------------------------------------------------
// octree_child_octet_gather
// Top level: child table with bisect-and-scan octant gather.
// ----------------------------------------------------------------------------
module octree_child_octet_gather
    import ocg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [24:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [24:0] i_coord_x,
    input  logic [24:0] i_coord_y,
    input  logic [24:0] i_coord_z,
    input  logic [31:0] i_payload,
    input  logic [23:0] i_parent_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_parent_echo,
    output logic [2:0]  o_octant,
    output logic [24:0] o_out_x,
    output logic [24:0] o_out_y,
    output logic [24:0] o_out_z,
    output logic [31:0] o_out_value,
    output logic        o_slot_found,
    output logic [7:0]  o_found_count,
    output logic        o_count_wrong,
    output logic        o_last
);
    logic [24:0] r_cell;
    logic busy, acc, last_k;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cell <= 25'd65536;
        else if (i_cfg_we) r_cell <= i_cfg_wdata;
    end

    assign o_stall = busy;
    assign acc = i_valid && !busy;

    ocg_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_go        (acc && i_req_type == REQ_QUERY),
        .i_sts       (sts),
        .i_out_taken (o_valid && !i_stall),
        .i_emit_last (last_k),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_out_valid (o_valid)
    );

    ocg_dp u_dp (
        .i_clk, .i_rst_n,
        .i_load  (acc && i_req_type == REQ_LOAD),
        .i_clear (acc && i_req_type == REQ_CLEAR),
        .i_cell_size (r_cell),
        .i_coord_x, .i_coord_y, .i_coord_z, .i_payload, .i_parent_index,
        .i_cmd (cmd), .o_sts (sts), .o_emit_last (last_k),
        .o_parent_echo, .o_octant, .o_out_x, .o_out_y, .o_out_z,
        .o_out_value, .o_slot_found, .o_found_count, .o_count_wrong
    );
    assign o_last = last_k;
endmodule

// File: design/ocg_checker.sv
// ----------------------------------------------------------------------------
// ocg_checker
// Port-level checks for the octet gather.
// ----------------------------------------------------------------------------
module ocg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_stall,
    input logic [2:0] o_octant,
    input logic       o_last
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_octant == 3'd7))) else $error("last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_octant)) else $error("hold");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("busy");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid && o_octant == $past(o_octant) + 3'd1)
        else $error("order");
endmodule

bind octree_child_octet_gather ocg_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_stall, .o_octant, .o_last
);
